[rtl/bsa_pkg.sv]
package bsa_pkg;

   localparam int unsigned MS_PER_SEC = 1000;
   localparam int DELAY_MS_W = 26;
   localparam int CH0_BIT = 0;
   localparam int CH1_BIT = 1;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_THRESHOLD_CH0   = 3'd0;
   localparam csr_index_type CSR_THRESHOLD_CH1   = 3'd1;
   localparam csr_index_type CSR_NOTIFY_DELAY    = 3'd2;
   localparam csr_index_type CSR_ALARM_ENABLE    = 3'd3;
   localparam csr_index_type CSR_CHANNEL_ENABLE  = 3'd4;

   localparam logic [1:0] CHANNEL_MASK_RESET = 2'b11;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               ch0_valid;
      logic signed [15:0] ch0_mv;
      logic               ch1_valid;
      logic signed [15:0] ch1_mv;
      logic               io_ready;
   } poll_type;

   typedef struct packed {
      logic blowers_ok;
      logic below_threshold;
      logic alarm_level;
      logic publish_strobe;
      logic publish_value;
   } result_type;

   typedef struct packed {
      logic signed [15:0]    threshold_ch0_mv;
      logic signed [15:0]    threshold_ch1_mv;
      logic [DELAY_MS_W-1:0] delay_ms;
      logic                  alarm_enable;
      logic [1:0]            channel_enable_mask;
   } cfg_type;

endpackage

[rtl/bsa_if.sv]
interface bsa_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        now_ms;
   logic               ch0_valid;
   logic signed [15:0] ch0_mv;
   logic               ch1_valid;
   logic signed [15:0] ch1_mv;
   logic               io_ready;

   modport source (output valid, output now_ms, output ch0_valid, output ch0_mv,
                   output ch1_valid, output ch1_mv, output io_ready, input ready);
   modport sink (input valid, input now_ms, input ch0_valid, input ch0_mv,
                 input ch1_valid, input ch1_mv, input io_ready, output ready);
endinterface

interface bsa_rsp_if;
   logic valid;
   logic ready;
   logic blowers_ok;
   logic below_threshold;
   logic alarm_level;
   logic publish_strobe;
   logic publish_value;

   modport source (output valid, output blowers_ok, output below_threshold,
                   output alarm_level, output publish_strobe, output publish_value,
                   input ready);
   modport sink (input valid, input blowers_ok, input below_threshold,
                 input alarm_level, input publish_strobe, input publish_value,
                 output ready);
endinterface

interface bsa_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [15:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

[rtl/bsa_csr.sv]
module bsa_csr (
   input  logic              clock,
   input  logic              reset,
   bsa_csr_if.sink           csr_ch,
   output bsa_pkg::cfg_type  cfg
);

   bsa_pkg::cfg_type cfg_ff;
   bsa_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.addr)
            bsa_pkg::CSR_THRESHOLD_CH0: cfg_in.threshold_ch0_mv = csr_ch.data;
            bsa_pkg::CSR_THRESHOLD_CH1: cfg_in.threshold_ch1_mv = csr_ch.data;
            bsa_pkg::CSR_NOTIFY_DELAY: begin
               cfg_in.delay_ms = bsa_pkg::DELAY_MS_W'(32'(csr_ch.data) * bsa_pkg::MS_PER_SEC);
            end
            bsa_pkg::CSR_ALARM_ENABLE: cfg_in.alarm_enable = csr_ch.data[0];
            bsa_pkg::CSR_CHANNEL_ENABLE: cfg_in.channel_enable_mask = csr_ch.data[1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_ch0_mv    <= '0;
         cfg_ff.threshold_ch1_mv    <= '0;
         cfg_ff.delay_ms            <= '0;
         cfg_ff.alarm_enable        <= 1'b0;
         cfg_ff.channel_enable_mask <= bsa_pkg::CHANNEL_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/bsa_eval.sv]
module bsa_eval #(
   parameter int unsigned PULSE_ON_MS  = 10000,
   parameter int unsigned PULSE_OFF_MS = 25000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bsa_pkg::cfg_type     cfg,
   input  bsa_pkg::poll_type    poll,
   input  logic                 fire,
   output bsa_pkg::result_type  result
);

   logic        cand_state_ff, cand_state_in;
   logic [31:0] cand_start_ff, cand_start_in;
   logic        stable_ff, stable_in;
   logic        has_pub_ff, has_pub_in;
   logic        last_pub_ff, last_pub_in;
   logic        cycle_active_ff, cycle_active_in;
   logic        phase_on_ff, phase_on_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic        driven_ff, driven_in;

   logic        en0, en1, ok0, ok1, any_en, blowers_ok;
   logic [31:0] cand_age, phase_age;
   logic        cand_aged, alarm_on, cand_change, settled, strobe;

   always_comb begin
      en0 = cfg.channel_enable_mask[bsa_pkg::CH0_BIT];
      en1 = cfg.channel_enable_mask[bsa_pkg::CH1_BIT];
      ok0 = en0 & poll.ch0_valid & (poll.ch0_mv >= cfg.threshold_ch0_mv);
      ok1 = en1 & poll.ch1_valid & (poll.ch1_mv >= cfg.threshold_ch1_mv);
      any_en = en0 | en1;
      blowers_ok = any_en & (ok0 | ~en0) & (ok1 | ~en1);

      cand_age  = poll.now_ms - cand_start_ff;
      cand_aged = cand_age >= 32'(cfg.delay_ms);
      phase_age = poll.now_ms - phase_start_ff;
      alarm_on  = cfg.alarm_enable & ~blowers_ok & cand_aged;

      cycle_active_in = cycle_active_ff;
      phase_on_in     = phase_on_ff;
      phase_start_in  = phase_start_ff;
      driven_in       = driven_ff;
      if (poll.io_ready) begin
         if (alarm_on != cycle_active_ff) begin
            // A phase that starts on this poll has no time elapsed yet.
            cycle_active_in = alarm_on;
            phase_on_in     = alarm_on;
            phase_start_in  = poll.now_ms;
            driven_in       = alarm_on;
         end else if (cycle_active_ff) begin
            if (phase_on_ff) begin
               if (phase_age >= 32'(PULSE_ON_MS)) begin
                  phase_on_in    = 1'b0;
                  phase_start_in = poll.now_ms;
               end
            end else if (phase_age >= 32'(PULSE_OFF_MS)) begin
               phase_on_in    = 1'b1;
               phase_start_in = poll.now_ms;
            end
            driven_in = phase_on_in;
         end
      end

      cand_change   = blowers_ok != cand_state_ff;
      cand_state_in = blowers_ok;
      cand_start_in = cand_change ? poll.now_ms : cand_start_ff;
      settled       = cand_change ? (cfg.delay_ms == '0) : cand_aged;

      stable_in   = stable_ff;
      has_pub_in  = has_pub_ff;
      last_pub_in = last_pub_ff;
      strobe      = 1'b0;
      if ((blowers_ok != stable_ff) && settled) begin
         stable_in = blowers_ok;
         if (!has_pub_ff || (blowers_ok != last_pub_ff)) begin
            strobe      = 1'b1;
            last_pub_in = blowers_ok;
            has_pub_in  = 1'b1;
         end
      end

      result.blowers_ok      = blowers_ok;
      result.below_threshold = any_en & ~blowers_ok;
      result.alarm_level     = driven_in;
      result.publish_strobe  = strobe;
      result.publish_value   = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_state_ff   <= 1'b0;
         cand_start_ff   <= '0;
         stable_ff       <= 1'b0;
         has_pub_ff      <= 1'b0;
         last_pub_ff     <= 1'b0;
         cycle_active_ff <= 1'b0;
         phase_on_ff     <= 1'b0;
         phase_start_ff  <= '0;
         driven_ff       <= 1'b0;
      end else if (fire) begin
         cand_state_ff   <= cand_state_in;
         cand_start_ff   <= cand_start_in;
         stable_ff       <= stable_in;
         has_pub_ff      <= has_pub_in;
         last_pub_ff     <= last_pub_in;
         cycle_active_ff <= cycle_active_in;
         phase_on_ff     <= phase_on_in;
         phase_start_ff  <= phase_start_in;
         driven_ff       <= driven_in;
      end
   end

endmodule

[rtl/blower_supervisor_alarm.sv]
// Channel   Port     Direction  Contents
// poll      req_ch   in         timestamp, two channel readings, IO ready
// result    rsp_ch   out        blower state, alarm level, publish strobe and value
// config    csr_ch   in         register index and write data
//
// One item is accepted every cycle while the result is not stalled; each item passes
// through the input register and then the result register, and the state update is
// done combinationally between them. Reset is synchronous and clears the supervisor
// state, the valid flags and the configuration but for the channel mask, which resets
// to both channels enabled; the item and result data registers are not cleared.
// A stalled result holds in the result register while one further item waits.
module blower_supervisor_alarm #(
   parameter int unsigned PULSE_ON_MS  = 10000,
   parameter int unsigned PULSE_OFF_MS = 25000
) (
   input  logic        clock,
   input  logic        reset,
   bsa_req_if.sink     req_ch,
   bsa_rsp_if.source   rsp_ch,
   bsa_csr_if.sink     csr_ch
);

   bsa_pkg::cfg_type    cfg;
   bsa_pkg::poll_type   poll_ff, poll_in;
   bsa_pkg::result_type result_ff, result_in;
   logic                poll_valid_ff, poll_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free, fire, accept;

   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign fire         = poll_valid_ff & out_free;
   assign req_ch.ready = ~poll_valid_ff | out_free;
   assign accept       = req_ch.valid & req_ch.ready;

   always_comb begin
      poll_in.now_ms    = req_ch.now_ms;
      poll_in.ch0_valid = req_ch.ch0_valid;
      poll_in.ch0_mv    = req_ch.ch0_mv;
      poll_in.ch1_valid = req_ch.ch1_valid;
      poll_in.ch1_mv    = req_ch.ch1_mv;
      poll_in.io_ready  = req_ch.io_ready;
      poll_valid_in     = accept | (poll_valid_ff & ~fire);
      rsp_valid_in      = fire | (rsp_valid_ff & ~rsp_ch.ready);
   end

   bsa_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bsa_eval #(
      .PULSE_ON_MS  (PULSE_ON_MS),
      .PULSE_OFF_MS (PULSE_OFF_MS)
   ) u_eval (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .poll   (poll_ff),
      .fire   (fire),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         poll_ff <= poll_in;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.blowers_ok      = result_ff.blowers_ok;
   assign rsp_ch.below_threshold = result_ff.below_threshold;
   assign rsp_ch.alarm_level     = result_ff.alarm_level;
   assign rsp_ch.publish_strobe  = result_ff.publish_strobe;
   assign rsp_ch.publish_value   = result_ff.publish_value;

endmodule

[rtl/bsa_checker.sv]
module bsa_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic blowers_ok,
   input logic below_threshold,
   input logic alarm_level,
   input logic publish_strobe,
   input logic publish_value
);

   // A stalled result must hold every field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(blowers_ok) &&
      $stable(below_threshold) && $stable(alarm_level) &&
      $stable(publish_strobe) && $stable(publish_value))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(blowers_ok && below_threshold))
      else $error("blowers both OK and below threshold");

   // A published change always carries the state seen on that poll.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && publish_strobe |-> publish_value == blowers_ok)
      else $error("published value differs from the polled state");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

endmodule

bind blower_supervisor_alarm bsa_checker u_bsa_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .blowers_ok      (rsp_ch.blowers_ok),
   .below_threshold (rsp_ch.below_threshold),
   .alarm_level     (rsp_ch.alarm_level),
   .publish_strobe  (rsp_ch.publish_strobe),
   .publish_value   (rsp_ch.publish_value)
);
